// File: hw/rtl/cne_pkg.sv
// Shared types and constants for the character n-gram extractor.
// Depends on nothing; used by char_ngram_extractor_core.
`default_nettype none

package cne_pkg;

   // Byte that separates words
   localparam logic [7:0] SPACE_CHAR = 8'd32;

   // Word length counter saturates here
   localparam logic [3:0] COUNT_MAX = 4'd15;

   // Reset value of the n-gram length register
   localparam logic [3:0] NGRAM_LEN_RESET = 4'd3;

   // Field widths of the result word
   localparam int unsigned NGRAM_BYTES_W = 64;
   localparam int unsigned NGRAM_CHARS_W = 4;
   localparam int unsigned RSP_DATA_W    = 72;

   // One result word before packing
   typedef struct packed {
      logic [NGRAM_CHARS_W-1:0] ngram_chars;
      logic [NGRAM_BYTES_W-1:0] ngram_bytes;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/char_ngram_extractor_core.sv
// Character n-gram extractor: top level, single-pass datapath with output skid.
// Depends on cne_pkg (scoped references only).
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+-----------------------------------------
//   req      | in  | req_tvalid/req_tready | req_tdata[7:0] text_byte, req_tlast string_end
//   rsp      | out | rsp_tvalid/rsp_tready | rsp_tdata ngram_bytes, ngram_chars, zero pad
//   csr      | in  | csr_wr_en             | csr_wr_data[3:0] ngram_length
//
// One word per cycle while req_tready is high: the window shift, length count and n-gram
// select are done in the accept cycle and registered into the result register or skid.
// A two-entry output (result register plus skid) keeps req_tready a pure
// register, so input words keep flowing while one result waits.
// Reset clears the window, the length count, both output entries and sets
// the n-gram length to 3.
`default_nettype none

module char_ngram_extractor_core #(
   parameter int unsigned MAX_NGRAM = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] text_byte
   input  wire logic        req_tlast,    // string_end
   // response side
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [cne_pkg::RSP_DATA_W-1:0] rsp_tdata,
                                          // [63:0] ngram_bytes, [67:64] ngram_chars,
                                          // [71:68] zero
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data   // ngram_length
);

   localparam int unsigned WIN_W = 8 * MAX_NGRAM;
   localparam logic [3:0]  MAX_N = 4'(MAX_NGRAM);

   // state
   logic [3:0]       ngram_len_ff;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [3:0]       count_ff, count_in;

   // output stage
   logic                 out_valid_ff, out_valid_in;
   cne_pkg::result_type  out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   cne_pkg::result_type  skid_ff, skid_in;

   logic                 accept;
   logic                 out_fire;
   logic                 is_space;
   logic [3:0]           eff_len;
   logic [WIN_W-1:0]     shifted;
   logic [3:0]           count_inc;
   logic                 has_result;
   logic [WIN_W-1:0]     sel_window;
   logic [3:0]           sel_len;
   logic [3:0]           shamt;
   logic [WIN_W-1:0]     sel_bytes;
   cne_pkg::result_type  new_result;

   assign accept     = req_tvalid && req_tready;
   assign out_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;

   // clamp the configured length into 1..MAX_NGRAM
   always_comb begin
      if (ngram_len_ff == 4'd0) begin
         eff_len = 4'd1;
      end else if (ngram_len_ff > MAX_N) begin
         eff_len = MAX_N;
      end else begin
         eff_len = ngram_len_ff;
      end
   end

   // window shift and word length for a non-space byte
   assign is_space  = (req_tdata == cne_pkg::SPACE_CHAR);
   assign shifted   = {req_tdata, window_ff[WIN_W-1:8]};
   assign count_inc = (count_ff < cne_pkg::COUNT_MAX) ? count_ff + 4'd1 : count_ff;

   // decide whether a result comes out and which bytes it carries
   always_comb begin
      if (is_space) begin
         has_result = (count_ff != 4'd0) && (count_ff < eff_len);
         sel_window = window_ff;
         sel_len    = count_ff;
      end else if (count_inc >= eff_len) begin
         has_result = 1'b1;
         sel_window = shifted;
         sel_len    = eff_len;
      end else begin
         has_result = req_tlast;
         sel_window = shifted;
         sel_len    = count_inc;
      end
   end

   // newest byte sits on top: drop the older bytes below the selected run
   assign shamt     = MAX_N - sel_len;
   assign sel_bytes = sel_window >> {shamt, 3'b000};

   assign new_result.ngram_bytes = cne_pkg::NGRAM_BYTES_W'(sel_bytes);
   assign new_result.ngram_chars = sel_len;

   // next window and count: cleared at a space or at the string end
   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      if (accept) begin
         if (is_space || req_tlast) begin
            window_in = '0;
            count_in  = 4'd0;
         end else begin
            window_in = shifted;
            count_in  = count_inc;
         end
      end
   end

   // result register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && has_result;
            out_in       = new_result;
         end
      end else if (accept && has_result) begin
         skid_valid_in = 1'b1;
         skid_in       = new_result;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ngram_len_ff  <= cne_pkg::NGRAM_LEN_RESET;
         window_ff     <= '0;
         count_ff      <= 4'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ngram_len_ff <= csr_wr_data;
         end
         window_ff     <= window_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = cne_pkg::RSP_DATA_W'(out_ff);

endmodule

`default_nettype wire
